@@ hw/rtl/mrt_pkg.sv @@
package mrt_pkg;

	// Input command codes
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_RX    = 2'd2;

	// Pending operation codes
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_CRC    = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// Result kinds
	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	// Modbus function codes
	localparam logic [7:0] FN_READ  = 8'h03;
	localparam logic [7:0] FN_WRITE = 8'h06;
	localparam logic [7:0] EXC_BIT  = 8'h80;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] READ_COUNT = 16'h0001;

	// Request frame byte positions
	localparam logic [2:0] POS_FUNC    = 3'd1;
	localparam logic [2:0] POS_ADDR_HI = 3'd2;
	localparam logic [2:0] POS_ADDR_LO = 3'd3;
	localparam logic [2:0] POS_DATA_HI = 3'd4;
	localparam logic [2:0] POS_DATA_LO = 3'd5;
	localparam logic [2:0] POS_CRC_LO  = 3'd6;
	localparam logic [2:0] POS_CRC_HI  = 3'd7;

	localparam int QUEUE_DEPTH = 2;
	localparam int CAP_BYTES   = 5;

	// One job handed from front to back: either a frame to send or a finished result
	typedef struct packed {
		logic        is_frame;
		logic [7:0]  unit_id;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] data;    // value/count for a frame, read value for a result
		logic [1:0]  status;
	} mrt_job_t;

	// Reflected CRC-16, one byte, eight bit steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/mrt_req_if.sv @@
interface mrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  unit_id;
	logic [15:0] reg_address;
	logic [15:0] reg_value;
	logic [7:0]  rx_byte;
	logic        rx_last;

	modport source(output valid, command, unit_id, reg_address, reg_value, rx_byte, rx_last,
		input ready);
	modport sink(input valid, command, unit_id, reg_address, reg_value, rx_byte, rx_last,
		output ready);
endinterface

@@ hw/rtl/mrt_res_if.sv @@
interface mrt_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic [1:0]  status;
	logic [15:0] read_value;

	modport source(output valid, kind, tx_byte, tx_last, status, read_value, input ready);
	modport sink(input valid, kind, tx_byte, tx_last, status, read_value, output ready);
endinterface

@@ hw/rtl/modbus_rtu_register_transactor_core.sv @@
// Channel   | Dir | Fields
// ----------+-----+---------------------------------------------------------------
// request   | in  | command, unit_id, reg_address, reg_value, rx_byte, rx_last
// result    | out | kind, tx_byte, tx_last, status, read_value
//
// A response byte is taken every cycle the queue is not full; its CRC step and, on
// the last byte, the frame check finish in the cycle it is accepted, in the front.
// A read/write request yields 8 frame bytes, one per cycle unless the result side
// stalls, from the back's output register; the back's byte walker orders them.
// The 2-entry job queue lets the front keep taking items while the back drains.
// Reset (arst_n low) clears the pending request, receive state and all queues.
// Either side may stall freely; request.ready drops only when the queue is full.
module modbus_rtu_register_transactor_core import mrt_pkg::*; #(
	parameter int MAX_FRAME = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	mrt_req_if.sink    request,
	mrt_res_if.source  result
);

	// front -> queue
	logic     push;
	mrt_job_t job;

	// queue -> back
	logic     pop, full, empty;
	mrt_job_t head;

	// Front: tracks the pending request, runs the receive CRC and capture, and turns
	// each request into a frame job and each last response byte into a finished result.
	mrt_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (request),
		.q_full (full),
		.push   (push),
		.job    (job)
	);

	mrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.rd_job (head),
		.full   (full),
		.empty  (empty)
	);

	// Back: serializes request frames with their CRC and hands out results.
	mrt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.res    (result)
	);

endmodule

@@ hw/rtl/mrt_front.sv @@
module mrt_front import mrt_pkg::*; #(
	parameter int MAX_FRAME = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	mrt_req_if.sink   req,
	input  logic      q_full,
	output logic      push,
	output mrt_job_t  job
);

	localparam int CntW = $clog2(MAX_FRAME + 1);

	logic [1:0]       op_q;
	logic [15:0]      addr_q;
	logic [15:0]      val_q;
	logic [15:0]      crc_q;
	logic [CntW-1:0]  cnt_q;
	logic [7:0]       held_q [2];
	logic [7:0]       cap_q [CAP_BYTES];

	logic             acc, is_req, is_rx, is_rd_req, in_frame;
	logic [15:0]      crc_n;
	logic [CntW-1:0]  cnt_n;
	logic [7:0]       held_n [2];
	logic [7:0]       cap_n [CAP_BYTES];
	logic [1:0]       status;
	logic [15:0]      rd_val;

	assign req.ready = !q_full;
	assign acc       = req.valid && req.ready;
	assign is_req    = (req.command == CMD_READ) || (req.command == CMD_WRITE);
	assign is_rd_req = req.command == CMD_READ;
	assign is_rx     = (req.command == CMD_RX) && (op_q != OP_NONE);
	assign in_frame  = cnt_q < CntW'(MAX_FRAME);

	always_comb begin
		crc_n     = (in_frame && cnt_q >= CntW'(2)) ? crc16_byte(crc_q, held_q[0]) : crc_q;
		held_n[0] = in_frame ? held_q[1] : held_q[0];
		held_n[1] = in_frame ? req.rx_byte : held_q[1];
		cnt_n     = in_frame ? cnt_q + CntW'(1) : cnt_q;
		for (int k = 0; k < CAP_BYTES; k++) begin
			cap_n[k] = (in_frame && cnt_q == CntW'(k + 1)) ? req.rx_byte : cap_q[k];
		end

		rd_val = 16'h0000;
		priority if (cnt_n < CntW'(3)) begin
			status = ST_CRC;
		end else if ({held_n[1], held_n[0]} != crc_n) begin
			status = ST_CRC;
		end else if (op_q == OP_READ) begin
			if (cnt_n >= CntW'(5) && cap_n[0] == FN_READ && (cap_n[0] & EXC_BIT) == 8'h00)
			begin
				status = ST_OK;
				rd_val = {cap_n[2], cap_n[3]};
			end else begin
				status = ST_REJECT;
			end
		end else begin
			if (cnt_n >= CntW'(6) && cap_n[0] == FN_WRITE && {cap_n[1], cap_n[2]} == addr_q
				&& {cap_n[3], cap_n[4]} == val_q) begin
				status = ST_OK;
			end else begin
				status = ST_REJECT;
			end
		end
	end

	assign push = acc && (is_req || (is_rx && req.rx_last));

	always_comb begin
		job.is_frame = is_req;
		job.unit_id  = req.unit_id;
		job.func     = is_rd_req ? FN_READ : FN_WRITE;
		job.addr     = req.reg_address;
		job.data     = is_req ? (is_rd_req ? READ_COUNT : req.reg_value) : rd_val;
		job.status   = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_NONE;
			addr_q    <= '0;
			val_q     <= '0;
			crc_q     <= CRC_INIT;
			cnt_q     <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			for (int k = 0; k < CAP_BYTES; k++) begin
				cap_q[k] <= '0;
			end
		end else if (acc && is_req) begin
			op_q      <= is_rd_req ? OP_READ : OP_WRITE;
			addr_q    <= req.reg_address;
			val_q     <= is_rd_req ? 16'h0000 : req.reg_value;
			crc_q     <= CRC_INIT;
			cnt_q     <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			for (int k = 0; k < CAP_BYTES; k++) begin
				cap_q[k] <= '0;
			end
		end else if (acc && is_rx) begin
			crc_q     <= crc_n;
			cnt_q     <= cnt_n;
			held_q[0] <= held_n[0];
			held_q[1] <= held_n[1];
			for (int k = 0; k < CAP_BYTES; k++) begin
				cap_q[k] <= cap_n[k];
			end
			if (req.rx_last) begin
				op_q <= OP_NONE;
			end
		end
	end

endmodule

@@ hw/rtl/mrt_queue.sv @@
module mrt_queue import mrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  mrt_job_t wr_job,
	input  logic     pop,
	output mrt_job_t rd_job,
	output logic     full,
	output logic     empty
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);

	mrt_job_t             mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]      wr_q, rd_q;
	logic [PtrW:0]        cnt_q;

	assign full   = cnt_q == (PtrW + 1)'(QUEUE_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			end
			cnt_q <= cnt_q + (PtrW + 1)'(push && !full) - (PtrW + 1)'(pop && !empty);
		end
	end

endmodule

@@ hw/rtl/mrt_back.sv @@
module mrt_back import mrt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mrt_job_t  head,
	input  logic      empty,
	output logic      pop,
	mrt_res_if.source res
);

	logic        ov_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  func_q;
	logic [15:0] addr_q, data_q;

	logic        kind_q, last_q;
	logic [7:0]  byte_q;
	logic [1:0]  status_q;
	logic [15:0] value_q;

	logic        load;
	logic [7:0]  cur;

	assign load = !ov_q || res.ready;
	assign pop  = load && !busy_q && !empty;

	always_comb begin
		unique case (idx_q)
			POS_FUNC:    cur = func_q;
			POS_ADDR_HI: cur = addr_q[15:8];
			POS_ADDR_LO: cur = addr_q[7:0];
			POS_DATA_HI: cur = data_q[15:8];
			POS_DATA_LO: cur = data_q[7:0];
			POS_CRC_LO:  cur = crc_q[7:0];
			POS_CRC_HI:  cur = crc_q[15:8];
			default:     cur = 8'h00;
		endcase
	end

	// frame walker: one byte per free output slot, CRC folded in as bytes go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			if (busy_q) begin
				ov_q  <= 1'b1;
				idx_q <= idx_q + 3'd1;
				if (idx_q == POS_CRC_HI) begin
					busy_q <= 1'b0;
				end
			end else if (!empty) begin
				ov_q <= 1'b1;
				if (head.is_frame) begin
					busy_q <= 1'b1;
					idx_q  <= POS_FUNC;
				end
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (busy_q) begin
				kind_q   <= KIND_FRAME;
				byte_q   <= cur;
				last_q   <= idx_q == POS_CRC_HI;
				status_q <= ST_OK;
				value_q  <= 16'h0000;
				if (idx_q < POS_CRC_LO) begin
					crc_q <= crc16_byte(crc_q, cur);
				end
			end else if (!empty) begin
				if (head.is_frame) begin
					kind_q   <= KIND_FRAME;
					byte_q   <= head.unit_id;
					last_q   <= 1'b0;
					status_q <= ST_OK;
					value_q  <= 16'h0000;
					crc_q    <= crc16_byte(CRC_INIT, head.unit_id);
					func_q   <= head.func;
					addr_q   <= head.addr;
					data_q   <= head.data;
				end else begin
					kind_q   <= KIND_RESULT;
					byte_q   <= 8'h00;
					last_q   <= 1'b0;
					status_q <= head.status;
					value_q  <= head.data;
				end
			end
		end
	end

	assign res.valid      = ov_q;
	assign res.kind       = kind_q;
	assign res.tx_byte    = byte_q;
	assign res.tx_last    = last_q;
	assign res.status     = status_q;
	assign res.read_value = value_q;

endmodule
